>>> src/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared constants, types and tables for the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlkW    = 16;
  localparam int unsigned RndW    = 7;
  localparam int unsigned PosW    = 4;
  localparam int unsigned NbW     = 4;
  localparam int unsigned IdxW    = 3;

  localparam logic [WordW-1:0] PadOneWord = 64'h8000000000000000;

  // Source of a word pushed into the block buffer.
  typedef enum logic [2:0] {
    SelIn,
    SelOne,
    SelZero,
    SelLenHi,
    SelLenLo
  } push_sel_e;

  typedef struct packed {
    logic            push;
    push_sel_e       sel;
    logic            rnd_en;
    logic [RndW-1:0] rnd;
    logic            feed;
    logic            clear;
    logic [IdxW-1:0] oidx;
  } dp_cmd_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            last_full;
  } dp_sts_t;

  function automatic logic [WordW-1:0] init_vec(input logic [IdxW-1:0] i);
    logic [WordW-1:0] r;
    case (i)
      3'd0:    r = 64'h6a09e667f3bcc908;
      3'd1:    r = 64'hbb67ae8584caa73b;
      3'd2:    r = 64'h3c6ef372fe94f82b;
      3'd3:    r = 64'ha54ff53a5f1d36f1;
      3'd4:    r = 64'h510e527fade682d1;
      3'd5:    r = 64'h9b05688c2b3e6c1f;
      3'd6:    r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] t);
    logic [WordW-1:0] r;
    case (t)
      7'd0:  r = 64'h428a2f98d728ae22;  7'd1:  r = 64'h7137449123ef65cd;
      7'd2:  r = 64'hb5c0fbcfec4d3b2f;  7'd3:  r = 64'he9b5dba58189dbbc;
      7'd4:  r = 64'h3956c25bf348b538;  7'd5:  r = 64'h59f111f1b605d019;
      7'd6:  r = 64'h923f82a4af194f9b;  7'd7:  r = 64'hab1c5ed5da6d8118;
      7'd8:  r = 64'hd807aa98a3030242;  7'd9:  r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c;  7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f;  7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235;  7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2;  7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5;  7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275;  7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4;  7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab;  7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f;  7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2;  7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f;  7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc;  7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed;  7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de;  7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6;  7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364;  7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791;  7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218;  7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a;  7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8;  7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99;  7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63;  7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373;  7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc;  7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72;  7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28;  7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915;  7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c;  7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e;  7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba;  7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae;  7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84;  7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc;  7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6;  7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec;  7'd79: r = 64'h6c44198c4a475817;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/sha512_if.sv
// ----------------------------------------------------------------------------
// SHA-512 channel interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sha512_in_if;
  logic                           valid;
  logic                           ready;
  logic [sha512_pkg::WordW-1:0]   data_word;
  logic [sha512_pkg::NbW-1:0]     valid_bytes;
  logic                           last_word;

  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha512_out_if;
  logic                           valid;
  logic                           ready;
  logic [sha512_pkg::WordW-1:0]   digest_word;
  logic [sha512_pkg::IdxW-1:0]    word_index;
  logic                           last_digest;

  modport source (output valid, digest_word, word_index, last_digest, input ready);
  modport sink   (input valid, digest_word, word_index, last_digest, output ready);
endinterface

>>> src/sha512_dp.sv
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Schedule shift line, round registers, hash state and byte counter.
// ----------------------------------------------------------------------------
module sha512_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sha512_pkg::dp_cmd_t           cmd_i,
  output sha512_pkg::dp_sts_t           sts_o,
  input  logic [sha512_pkg::WordW-1:0]  data_i,
  input  logic [sha512_pkg::NbW-1:0]    nbytes_i,
  input  logic                          last_i,
  output logic [sha512_pkg::WordW-1:0]  digest_o
);

  logic [sha512_pkg::WordW-1:0] w_q [sha512_pkg::BlkW];
  logic [sha512_pkg::WordW-1:0] v_q [8];
  logic [sha512_pkg::WordW-1:0] h_q [8];
  logic [sha512_pkg::WordW-1:0] cnt_q, cnt_d;
  logic [sha512_pkg::PosW-1:0]  pos_q;

  logic [sha512_pkg::NbW-1:0]   nb;
  logic [6:0]                   sh_keep, sh_pad;
  logic [sha512_pkg::WordW-1:0] keep, padw, in_word, push_word;
  logic [sha512_pkg::WordW-1:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Saturate the byte count of the last word to eight.
  assign nb      = (nbytes_i > 4'd8) ? 4'd8 : nbytes_i;
  assign sh_keep = 7'd64 - {nb, 3'b000};
  assign sh_pad  = 7'd56 - {nb, 3'b000};
  assign keep    = ~64'd0 << sh_keep;
  assign padw    = 64'h80 << sh_pad;
  assign in_word = (last_i && nb != 4'd8) ? ((data_i & keep) | padw) : data_i;

  always_comb begin
    case (cmd_i.sel)
      sha512_pkg::SelIn:    push_word = in_word;
      sha512_pkg::SelOne:   push_word = sha512_pkg::PadOneWord;
      sha512_pkg::SelLenHi: push_word = {61'd0, cnt_q[63:61]};
      sha512_pkg::SelLenLo: push_word = {cnt_q[60:0], 3'b000};
      default:              push_word = '0;
    endcase
  end

  assign s0    = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1    = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
  assign w_new = s1 + w_q[9] + s0 + w_q[0];

  assign big1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + sha512_pkg::round_k(cmd_i.rnd) + w_q[0];
  assign big0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.push && cmd_i.sel == sha512_pkg::SelIn) begin
      cnt_d = cnt_q + (last_i ? {60'd0, nb} : 64'd8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::init_vec(3'(i));
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.push) pos_q <= pos_q + 4'd1;
      if (cmd_i.clear) begin
        pos_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::init_vec(3'(i));
      end else if (cmd_i.feed) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.rnd_en) begin
      for (int i = 0; i < sha512_pkg::BlkW - 1; i++) w_q[i] <= w_q[i+1];
      w_q[sha512_pkg::BlkW-1] <= cmd_i.push ? push_word : w_new;
    end
    if (cmd_i.push && pos_q == 4'd15) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.rnd_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign sts_o.pos       = pos_q;
  assign sts_o.last_full = (nb == 4'd8);
  assign digest_o        = h_q[cmd_i.oidx];

endmodule

>>> src/sha512_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-512 controller
// Sequences word intake, padding, rounds, feed-forward and digest output.
// ----------------------------------------------------------------------------
module sha512_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sha512_pkg::dp_cmd_t  cmd_o,
  input  sha512_pkg::dp_sts_t  sts_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StFeed = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam logic [1:0] PhOne  = 2'd0;
  localparam logic [1:0] PhZero = 2'd1;
  localparam logic [1:0] PhLen  = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  logic [2:0]                  st_q, st_d;
  logic [1:0]                  ph_q, ph_d;
  logic                        fin_q, fin_d;
  logic [sha512_pkg::RndW-1:0] rnd_q, rnd_d;
  logic [sha512_pkg::IdxW-1:0] oidx_q, oidx_d;
  logic                        wrap;

  assign wrap = cmd_o.push && sts_i.pos == 4'd15;

  always_comb begin
    st_d         = st_q;
    ph_d         = ph_q;
    fin_d        = fin_q;
    rnd_d        = rnd_q;
    oidx_d       = oidx_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.sel    = sha512_pkg::SelIn;
    cmd_o.rnd    = rnd_q;
    cmd_o.oidx   = oidx_q;
    case (st_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          if (in_last_i) begin
            fin_d = 1'b1;
            ph_d  = sts_i.last_full ? PhOne : PhZero;
            st_d  = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.push = 1'b1;
        case (ph_q)
          PhOne: begin
            cmd_o.sel = sha512_pkg::SelOne;
            ph_d      = PhZero;
          end
          PhZero: begin
            if (sts_i.pos == 4'd14) begin
              cmd_o.sel = sha512_pkg::SelLenHi;
              ph_d      = PhLen;
            end else begin
              cmd_o.sel = sha512_pkg::SelZero;
            end
          end
          default: begin
            cmd_o.sel = sha512_pkg::SelLenLo;
            ph_d      = PhDone;
          end
        endcase
      end
      StComp: begin
        cmd_o.rnd_en = 1'b1;
        rnd_d        = rnd_q + 7'd1;
        if (rnd_q == 7'(sha512_pkg::Rounds - 1)) st_d = StFeed;
      end
      StFeed: begin
        cmd_o.feed = 1'b1;
        if (!fin_q) st_d = StIdle;
        else if (ph_q == PhDone) st_d = StOut;
        else st_d = StPad;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cmd_o.clear = 1'b1;
            fin_d       = 1'b0;
            st_d        = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
    // A push that fills the block starts the rounds.
    if (wrap) begin
      st_d  = StComp;
      rnd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ph_q   <= PhDone;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      oidx_q <= '0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      fin_q  <= fin_d;
      rnd_q  <= rnd_d;
      oidx_q <= oidx_d;
    end
  end

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StComp |-> rnd_q < 7'(sha512_pkg::Rounds)) else $error("round count out of range");
  a_wrap_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap |=> st_q == StComp && rnd_q == '0) else $error("full block did not start rounds");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |-> fin_q && ph_q == PhDone && sts_i.pos == '0)
    else $error("digest shown before padding finished");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while digest pending");
`endif

endmodule

>>> src/sha512_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Computes the SHA-512 digest of a message given as big-endian 64-bit words.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Word contents
// msg_i    in   data_word[63:0], valid_bytes[3:0], last_word
// dig_o    out  digest_word[63:0], word_index[2:0], last_digest
//
// Message words are taken only while the engine is idle. The sixteenth word
// of a block starts the compression: 80 rounds, one per cycle in the shared
// round unit, then a feed-forward step. The last word is followed by one pad
// or length word per cycle, held while a full block compresses; one or two
// more compressions follow, then eight digest words.
// Reset loads the initial hash vector and clears the counters; no item is
// taken while a block compresses or a digest waits on dig_o.

module sha512_hash_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha512_in_if.sink          msg_i,
  sha512_out_if.source       dig_o
);

  sha512_pkg::dp_cmd_t cmd;
  sha512_pkg::dp_sts_t sts;

  // The controller owns all sequencing; the datapath holds all words.
  sha512_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_last_i   (msg_i.last_word),
    .in_ready_o  (msg_i.ready),
    .out_valid_o (dig_o.valid),
    .out_ready_i (dig_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sha512_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .data_i   (msg_i.data_word),
    .nbytes_i (msg_i.valid_bytes),
    .last_i   (msg_i.last_word),
    .digest_o (dig_o.digest_word)
  );

  // Digest words leave in order, most significant first.
  assign dig_o.word_index  = cmd.oidx;
  assign dig_o.last_digest = (cmd.oidx == 3'd7);

endmodule

>>> sim/sha512_hash_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 hash engine testbench
// Feeds messages as 64-bit words, predicts each digest with an independent
// SHA-512 model and checks every digest word, under random flow control.
// ----------------------------------------------------------------------------

module sha512_hash_engine_test;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomWords = 360;

  typedef struct {
    logic [63:0] digest;
    logic [2:0]  idx;
    logic        fin;
  } digest_word_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    bit          fin;
    int          reps;
    bit          known;
    logic [63:0] first_digest;
  } msg_row_t;

  // Round constants and initial vector of FIPS 180-4, kept apart from the package.
  localparam logic [63:0] K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] H0 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha512_in_if  msg ();
  sha512_out_if dig ();

  sha512_hash_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg),
    .dig_o  (dig)
  );

  always #4 clk_i = ~clk_i;

  // Predicted engine state: chaining value, block under construction,
  // message byte count and next free word slot.
  logic [63:0] chain [8];
  logic [63:0] blk [16];
  logic [63:0] msg_bytes;
  logic [3:0]  slot;

  digest_word_t digest_q[$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned messages = 0;
  int unsigned digests_seen = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          long_hold_done = 1'b0;

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void compress_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 80; t++) begin
      s0 = rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7);
      s1 = rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void append_word(logic [63:0] w);
    blk[slot] = w;
    slot = slot + 4'd1;
    if (slot == 4'd0) compress_block();
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = H0[i];
    msg_bytes = '0;
    slot = '0;
  endfunction

  // Absorbs one accepted message word; on the final word it pads the message,
  // closes it out and queues the eight digest words.
  function automatic void absorb_message_word(logic [63:0] data, logic [3:0] nb, bit fin);
    logic [63:0] keep;
    int unsigned n;
    if (!fin) begin
      append_word(data);
      msg_bytes = msg_bytes + 64'd8;
      return;
    end
    n = (nb > 4'd8) ? 8 : nb;
    msg_bytes = msg_bytes + 64'(n);
    if (n == 8) begin
      append_word(data);
      append_word(64'h8000000000000000);
    end else begin
      keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
      append_word((data & keep) | (64'h80 << (56 - 8 * n)));
    end
    // The 128-bit length needs two free slots; otherwise pad out this block.
    if (slot > 4'd14) while (slot != 4'd0) append_word(64'd0);
    while (slot < 4'd14) append_word(64'd0);
    append_word(msg_bytes >> 61);
    append_word(msg_bytes << 3);
    for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
    messages++;
    restart_message();
  endfunction

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("[%0t] digest mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Offers one word and waits for the handshake. The sender runs in bursts
  // with idle gaps in between; some bursts start with no gap at all.
  task automatic offer_word(logic [63:0] data, logic [3:0] nb, bit fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        msg.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    msg.valid       <= 1'b1;
    msg.data_word   <= data;
    msg.valid_bytes <= nb;
    msg.last_word   <= fin;
    do @(posedge clk_i); while (!msg.ready);
    burst_left--;
    words_sent++;
    absorb_message_word(data, nb, fin);
  endtask

  task automatic wait_for_digests();
    msg.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Result checker: every accepted digest word is compared with the oldest
  // prediction.
  always @(posedge clk_i) begin
    digest_word_t want;
    if (rst_ni && dig.valid && dig.ready) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        report_mismatch("unpredicted digest_word", 64'd0, dig.digest_word);
      end else begin
        want = digest_q.pop_front();
        if (dig.digest_word !== want.digest)
          report_mismatch("digest_word", want.digest, dig.digest_word);
        if (dig.word_index !== want.idx)
          report_mismatch("word_index", 64'(want.idx), 64'(dig.word_index));
        if (dig.last_digest !== want.fin)
          report_mismatch("last_digest", 64'(want.fin), 64'(dig.last_digest));
      end
    end
  end

  // Receiver: switches among stall patterns, and once holds off for a long
  // stretch so that a digest backs up and the input side stalls.
  initial begin
    int unsigned mode;
    dig.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk_i);
        case (mode)
          0: dig.ready <= 1'b1;
          1: dig.ready <= ($urandom_range(0, 3) != 0);
          default: dig.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (!long_hold_done && words_sent > 250) begin
        long_hold_done = 1'b1;
        @(posedge clk_i);
        dig.ready <= 1'b0;
        for (int c = 0; c < 600; c++) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycles, digest_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    msg_row_t rows [];
    int unsigned len;
    logic [3:0] nb;
    msg.valid       = 1'b0;
    msg.data_word   = '0;
    msg.valid_bytes = '0;
    msg.last_word   = 1'b0;
    restart_message();
    for (int i = 0; i < 16; i++) blk[i] = '0;

    // Directed messages. Known digests are typed in for the empty message
    // and for "abc"; the rest lean on the predictor.
    rows = '{
      '{64'h0, 4'd0, 1, 1, 1, 64'hcf83e1357eefb8bd},
      '{64'h6162630000000000, 4'd3, 1, 1, 1, 64'hddaf35a193617aba},
      // Valid bytes above eight on a full last word saturate.
      '{64'hffffffffffffffff, 4'd15, 1, 1, 0, 64'h0},
      // Valid bytes on inner words are ignored; unused bytes masked at the end.
      '{64'ha5a5a5a5a5a5a5a5, 4'd9, 0, 3, 0, 64'h0},
      '{64'h0123456789abcdef, 4'd5, 1, 1, 0, 64'h0},
      // Full last word as the 16th word: the pad word opens a new block.
      '{64'h5555555555555555, 4'd0, 0, 15, 0, 64'h0},
      '{64'hffffffffffffffff, 4'd8, 1, 1, 0, 64'h0},
      // Pad lands in slot 14, so the length needs an extra block.
      '{64'h3c3c3c3c3c3c3c3c, 4'd1, 0, 14, 0, 64'h0},
      '{64'hffffffffffffffff, 4'd7, 1, 1, 0, 64'h0},
      // Pad in slot 13: length just fits.
      '{64'h0f0f0f0f0f0f0f0f, 4'd8, 0, 13, 0, 64'h0},
      '{64'hfedcba9876543210, 4'd4, 1, 1, 0, 64'h0},
      // Empty last word right after a full block.
      '{64'h0000000000000000, 4'd15, 0, 16, 0, 64'h0},
      '{64'hffffffffffffffff, 4'd0, 1, 1, 0, 64'h0},
      '{64'h0, 4'd2, 0, 2, 0, 64'h0},
      '{64'h0, 4'd1, 1, 1, 0, 64'h0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      for (int k = 0; k < rows[r].reps; k++)
        offer_word(rows[r].data, rows[r].nbytes, rows[r].fin);
      if (rows[r].known) digest_q[digest_q.size() - 8].digest = rows[r].first_digest;
    end
    // Hold the sender until every predicted digest word has come back.
    wait_for_digests();

    // Random messages: mostly short, some around block boundaries, a few long.
    while (words_sent < RandomWords) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(13, 17);
        2:       len = $urandom_range(28, 34);
        default: len = $urandom_range(0, 12);
      endcase
      for (int i = 0; i < len; i++) offer_word(rand_word(), 4'($urandom_range(0, 15)), 0);
      nb = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      offer_word(rand_word(), nb, 1);
      if (words_sent > 300 && words_sent < 330) wait_for_digests();
    end

    wait_for_digests();
    repeat (200) @(posedge clk_i);

    $display("covered %0d message words in %0d messages, %0d digest words checked",
             words_sent, messages, digests_seen);
    $display("padding edges, saturated and zero byte counts, and stalls on both sides exercised");
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
